/* rtl/pidff_pkg.sv */
`timescale 1ns / 1ps

package pidff_pkg;

    localparam int DW       = 32;
    localparam int FRAC     = 16;
    localparam int FILT_SH  = 16;
    localparam int OPW      = 34;
    localparam int PRODW    = DW + OPW;

    typedef logic signed [DW-1:0]  data_t;
    typedef logic signed [OPW-1:0] oper_t;
    typedef logic [63:0]           limit_t;

    // Operation codes of an item
    localparam logic [2:0] FN_POS_INT = 3'd0;
    localparam logic [2:0] FN_POS_EXT = 3'd1;
    localparam logic [2:0] FN_INC_INT = 3'd2;
    localparam logic [2:0] FN_INC_EXT = 3'd3;
    localparam logic [2:0] FN_PRESET  = 3'd4;
    localparam logic [2:0] FN_CLEAR   = 3'd5;

    // Register indexes
    localparam logic [3:0] REG_KP     = 4'd0;
    localparam logic [3:0] REG_KI     = 4'd1;
    localparam logic [3:0] REG_KD     = 4'd2;
    localparam logic [3:0] REG_KFF    = 4'd3;
    localparam logic [3:0] REG_KFFB   = 4'd4;
    localparam logic [3:0] REG_FILT   = 4'd5;
    localparam logic [3:0] REG_ILIM   = 4'd6;
    localparam logic [3:0] REG_OLIM   = 4'd7;

    localparam data_t DMAX = {1'b0, {(DW-1){1'b1}}};
    localparam data_t DMIN = {1'b1, {(DW-1){1'b0}}};

    // Sign-extend a data word to operand width
    function automatic oper_t sx_op(input data_t v);
        sx_op = {{(OPW-DW){v[DW-1]}}, v};
    endfunction

    // Saturating add or subtract
    function automatic data_t sat_add(input data_t a, input data_t b, input logic sub);
        logic signed [DW+1:0] s;
        logic signed [DW+1:0] ea;
        logic signed [DW+1:0] eb;
        ea = {{2{a[DW-1]}}, a};
        eb = {{2{b[DW-1]}}, b};
        s  = sub ? (ea - eb) : (ea + eb);
        if (s > (DW+2)'(DMAX))
            sat_add = DMAX;
        else if (s < (DW+2)'(DMIN))
            sat_add = DMIN;
        else
            sat_add = s[DW-1:0];
    endfunction

    // Apply upper limit, then lower limit
    function automatic data_t clamp(input data_t x, input limit_t lim);
        data_t hi;
        data_t lo;
        data_t r;
        hi = lim[63:32];
        lo = lim[31:0];
        r  = x;
        if (r > hi)
            r = hi;
        if (r < lo)
            r = lo;
        clamp = r;
    endfunction

endpackage

/* rtl/pid_feedforward_controller_top.sv */
`timescale 1ns / 1ps

// PID step with feedforward in Q16.16. One item is taken at a time: a control step
// (func 0..3) passes in positional or incremental form through one shared 32x34
// multiplier that forms the nine products one per cycle, followed by one saturating
// adder that forms the sums one per cycle. Preset, clear and unused codes go straight
// to the finish state. The result sits in an output register; a new item is accepted
// once the sequencer is idle. Configuration writes are always ready.
module pid_feedforward_controller_top (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [2:0]           func,
    input  logic signed [31:0]   setpoint,
    input  logic signed [31:0]   feedback,
    input  logic signed [31:0]   ext_diff_error,
    input  logic signed [31:0]   preset_value,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic signed [31:0]   control_out,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [3:0]           cfg_index,
    input  logic [63:0]          cfg_data
);

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_KP     = 5'd1;
    localparam logic [4:0] S_KI     = 5'd2;
    localparam logic [4:0] S_KD     = 5'd3;
    localparam logic [4:0] S_KFF    = 5'd4;
    localparam logic [4:0] S_FFA    = 5'd5;
    localparam logic [4:0] S_FFB    = 5'd6;
    localparam logic [4:0] S_KFB    = 5'd7;
    localparam logic [4:0] S_BSA    = 5'd8;
    localparam logic [4:0] S_BSB    = 5'd9;
    localparam logic [4:0] S_FFSUM  = 5'd10;
    localparam logic [4:0] S_BSSUM  = 5'd11;
    localparam logic [4:0] S_P_INT  = 5'd12;
    localparam logic [4:0] S_P_ACC  = 5'd13;
    localparam logic [4:0] S_P_DER  = 5'd14;
    localparam logic [4:0] S_P_FF   = 5'd15;
    localparam logic [4:0] S_P_BST  = 5'd16;
    localparam logic [4:0] S_I_DD   = 5'd17;
    localparam logic [4:0] S_I_ACC  = 5'd18;
    localparam logic [4:0] S_I_DER  = 5'd19;
    localparam logic [4:0] S_I_DFF  = 5'd20;
    localparam logic [4:0] S_I_FF   = 5'd21;
    localparam logic [4:0] S_I_DBS  = 5'd22;
    localparam logic [4:0] S_I_BST  = 5'd23;
    localparam logic [4:0] S_I_OUT  = 5'd24;
    localparam logic [4:0] S_FIN    = 5'd25;

    // Configuration
    pidff_pkg::data_t  kp_reg, ki_reg, kd_reg, kff_reg, kffb_reg;
    logic [31:0]       filt_reg;
    pidff_pkg::limit_t ilim_reg, olim_reg;

    // Controller history
    pidff_pkg::data_t  h0_reg, h1_reg, fb_prev_reg, e_prev_reg, integ_reg;
    pidff_pkg::data_t  der_prev_reg, ff_prev_reg, bs_prev_reg, output_reg;

    // Item working registers
    logic [4:0]        state_reg, state_next;
    logic              incr_reg, ext_reg;
    pidff_pkg::data_t  sp_reg, fb_reg, e_reg, xd_reg;
    pidff_pkg::data_t  p_reg, inc_reg, der_reg, ffa_reg, ffb_reg, bsa_reg, bsb_reg;
    pidff_pkg::data_t  ff_reg, bs_reg, acc_reg, tmp_reg;
    logic              out_valid_reg;
    pidff_pkg::data_t  out_data_reg;

    logic              in_accept, out_take, fin_load;

    // Shared multiplier
    pidff_pkg::data_t  mul_a;
    pidff_pkg::oper_t  mul_b;
    logic              mul_sh17;
    logic signed [pidff_pkg::PRODW-1:0] mul_prod, mul_shr;
    pidff_pkg::data_t  mul_res;

    // Shared saturating adder
    pidff_pkg::data_t  add_a, add_b;
    logic              add_sub;
    pidff_pkg::data_t  add_res;

    assign in_accept = in_valid && !in_stall;
    assign out_take  = out_valid_reg && !out_stall;
    assign fin_load  = (state_reg == S_FIN) && (!out_valid_reg || !out_stall);
    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign control_out = out_data_reg;
    assign cfg_ready = 1'b1;

    // Select multiplier operands
    always_comb
    begin
        mul_a    = pidff_pkg::data_t'(0);
        mul_b    = pidff_pkg::oper_t'(0);
        mul_sh17 = 1'b0;
        case (state_reg)
            S_KP:
            begin
                mul_a = kp_reg;
                mul_b = incr_reg ? (pidff_pkg::sx_op(e_reg) - pidff_pkg::sx_op(e_prev_reg))
                                 : pidff_pkg::sx_op(e_reg);
            end
            S_KI:
            begin
                mul_a    = ki_reg;
                mul_b    = pidff_pkg::sx_op(e_reg) + pidff_pkg::sx_op(e_prev_reg);
                mul_sh17 = 1'b1;
            end
            S_KD:
            begin
                mul_a = kd_reg;
                mul_b = ext_reg ? pidff_pkg::sx_op(xd_reg)
                                : (pidff_pkg::sx_op(fb_reg) - pidff_pkg::sx_op(fb_prev_reg));
            end
            S_KFF:
            begin
                mul_a = kff_reg;
                mul_b = pidff_pkg::sx_op(sp_reg) - pidff_pkg::sx_op(h0_reg);
            end
            S_FFA:
            begin
                mul_a = ffa_reg;
                mul_b = pidff_pkg::oper_t'(18'h10000 - {2'b00, filt_reg[15:0]});
            end
            S_FFB:
            begin
                mul_a = ff_prev_reg;
                mul_b = pidff_pkg::oper_t'({2'b00, filt_reg[15:0]});
            end
            S_KFB:
            begin
                mul_a = kffb_reg;
                mul_b = pidff_pkg::sx_op(sp_reg) - (pidff_pkg::sx_op(h0_reg) <<< 1)
                        + pidff_pkg::sx_op(h1_reg);
            end
            S_BSA:
            begin
                mul_a = bsa_reg;
                mul_b = pidff_pkg::oper_t'(18'h10000 - {2'b00, filt_reg[31:16]});
            end
            S_BSB:
            begin
                mul_a = bs_prev_reg;
                mul_b = pidff_pkg::oper_t'({2'b00, filt_reg[31:16]});
            end
            default:
            begin
                mul_a = pidff_pkg::data_t'(0);
            end
        endcase
    end

    // Multiply, floor shift, saturate
    always_comb
    begin
        mul_prod = mul_a * mul_b;
        mul_shr  = mul_sh17 ? (mul_prod >>> (pidff_pkg::FRAC + 1))
                            : (mul_prod >>> pidff_pkg::FRAC);
        if (mul_shr > pidff_pkg::PRODW'(pidff_pkg::DMAX))
            mul_res = pidff_pkg::DMAX;
        else if (mul_shr < pidff_pkg::PRODW'(pidff_pkg::DMIN))
            mul_res = pidff_pkg::DMIN;
        else
            mul_res = mul_shr[pidff_pkg::DW-1:0];
    end

    // Select adder operands
    always_comb
    begin
        add_a   = acc_reg;
        add_b   = tmp_reg;
        add_sub = 1'b0;
        case (state_reg)
            S_FFSUM:
            begin
                add_a = ffa_reg;
                add_b = ffb_reg;
            end
            S_BSSUM:
            begin
                add_a = bsa_reg;
                add_b = bsb_reg;
            end
            S_P_INT:
            begin
                add_a = integ_reg;
                add_b = inc_reg;
            end
            S_P_ACC:
            begin
                add_a = p_reg;
                add_b = integ_reg;
            end
            S_P_DER:
            begin
                add_b   = der_reg;
                add_sub = 1'b1;
            end
            S_P_FF:  add_b = ff_reg;
            S_P_BST: add_b = bs_reg;
            S_I_DD:
            begin
                add_a   = der_reg;
                add_b   = der_prev_reg;
                add_sub = 1'b1;
            end
            S_I_ACC:
            begin
                add_a = p_reg;
                add_b = inc_reg;
            end
            S_I_DER: add_sub = 1'b1;
            S_I_DFF:
            begin
                add_a   = ff_reg;
                add_b   = ff_prev_reg;
                add_sub = 1'b1;
            end
            S_I_DBS:
            begin
                add_a   = bs_reg;
                add_b   = bs_prev_reg;
                add_sub = 1'b1;
            end
            S_I_OUT:
            begin
                add_a = output_reg;
                add_b = acc_reg;
            end
            default: add_sub = 1'b0;
        endcase
        add_res = pidff_pkg::sat_add(add_a, add_b, add_sub);
    end

    // Advance the sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                    state_next = (func <= pidff_pkg::FN_INC_EXT) ? S_KP : S_FIN;
            end
            S_BSSUM: state_next = incr_reg ? S_I_DD : S_P_INT;
            S_P_BST: state_next = S_FIN;
            S_I_OUT: state_next = S_FIN;
            S_FIN:   state_next = fin_load ? S_IDLE : S_FIN;
            default: state_next = state_reg + 5'd1;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (fin_load)
                out_valid_reg <= 1'b1;
            else if (out_take)
                out_valid_reg <= 1'b0;
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kp_reg   <= '0;
            ki_reg   <= '0;
            kd_reg   <= '0;
            kff_reg  <= '0;
            kffb_reg <= '0;
            filt_reg <= '0;
            ilim_reg <= '0;
            olim_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                pidff_pkg::REG_KP:   kp_reg   <= cfg_data[31:0];
                pidff_pkg::REG_KI:   ki_reg   <= cfg_data[31:0];
                pidff_pkg::REG_KD:   kd_reg   <= cfg_data[31:0];
                pidff_pkg::REG_KFF:  kff_reg  <= cfg_data[31:0];
                pidff_pkg::REG_KFFB: kffb_reg <= cfg_data[31:0];
                pidff_pkg::REG_FILT: filt_reg <= cfg_data[31:0];
                pidff_pkg::REG_ILIM: ilim_reg <= cfg_data;
                pidff_pkg::REG_OLIM: olim_reg <= cfg_data;
                default:             kp_reg   <= kp_reg;
            endcase
        end
    end

    // Controller history
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            h0_reg       <= '0;
            h1_reg       <= '0;
            fb_prev_reg  <= '0;
            e_prev_reg   <= '0;
            integ_reg    <= '0;
            der_prev_reg <= '0;
            ff_prev_reg  <= '0;
            bs_prev_reg  <= '0;
            output_reg   <= '0;
        end
        else
        begin
            if (in_accept && func == pidff_pkg::FN_PRESET)
                output_reg <= pidff_pkg::clamp(preset_value, olim_reg);
            if (in_accept && func == pidff_pkg::FN_CLEAR)
            begin
                h0_reg       <= '0;
                h1_reg       <= '0;
                fb_prev_reg  <= '0;
                e_prev_reg   <= '0;
                integ_reg    <= '0;
                der_prev_reg <= '0;
                ff_prev_reg  <= '0;
                bs_prev_reg  <= '0;
                output_reg   <= '0;
            end
            if (state_reg == S_P_INT)
                integ_reg <= pidff_pkg::clamp(add_res, ilim_reg);
            if (state_reg == S_P_BST || state_reg == S_I_OUT)
            begin
                output_reg   <= pidff_pkg::clamp(add_res, olim_reg);
                h1_reg       <= h0_reg;
                h0_reg       <= sp_reg;
                fb_prev_reg  <= fb_reg;
                e_prev_reg   <= e_reg;
                der_prev_reg <= der_reg;
                ff_prev_reg  <= ff_reg;
                bs_prev_reg  <= bs_reg;
            end
        end
    end

    // Item working registers
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            incr_reg <= func[1];
            ext_reg  <= func[0];
            sp_reg   <= setpoint;
            fb_reg   <= feedback;
            e_reg    <= pidff_pkg::sat_add(setpoint, feedback, 1'b1);
            xd_reg   <= ext_diff_error;
        end
        case (state_reg)
            S_KP:    p_reg   <= mul_res;
            S_KI:    inc_reg <= pidff_pkg::clamp(mul_res, ilim_reg);
            S_KD:    der_reg <= mul_res;
            S_KFF:   ffa_reg <= mul_res;
            S_FFA:   ffa_reg <= mul_res;
            S_FFB:   ffb_reg <= mul_res;
            S_KFB:   bsa_reg <= mul_res;
            S_BSA:   bsa_reg <= mul_res;
            S_BSB:   bsb_reg <= mul_res;
            S_FFSUM: ff_reg  <= add_res;
            S_BSSUM: bs_reg  <= add_res;
            S_P_ACC, S_P_DER, S_P_FF, S_I_ACC, S_I_DER, S_I_FF:
                     acc_reg <= add_res;
            S_I_BST: acc_reg <= pidff_pkg::clamp(add_res, ilim_reg);
            S_I_DD, S_I_DFF, S_I_DBS:
                     tmp_reg <= add_res;
            default: acc_reg <= acc_reg;
        endcase
        if (fin_load)
            out_data_reg <= output_reg;
    end

`ifndef SYNTHESIS
    a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |-> state_reg == S_IDLE)
        else $error("item accepted while sequencer busy");

    a_fin_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN && out_valid_reg && out_stall) |=> state_reg == S_FIN)
        else $error("result overwritten while output stalled");

    a_clear_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && func == pidff_pkg::FN_CLEAR) |=> (output_reg == '0 && integ_reg == '0))
        else $error("clear did not zero the state");

    a_fin_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        fin_load |=> (out_valid_reg && state_reg == S_IDLE))
        else $error("result not presented after finish");
`endif

endmodule
